[hdl/irt_pkg.sv]
`timescale 1ns / 1ps
// irt_pkg: shared types, constants and the digit-to-ascii function
// for the radix text converter; no dependencies
package irt_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int RADIX_W        = 6;
   localparam int FLAG_W         = 5;
   localparam int DIGIT_W        = 6;
   localparam int CHAR_W         = 8;

   localparam int FLAG_SIGNED = 0;
   localparam int FLAG_PLUS   = 1;
   localparam int FLAG_SPACE  = 2;
   localparam int FLAG_PREFIX = 3;
   localparam int FLAG_UPPER  = 4;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

   typedef struct packed {
      logic               clear;
      logic               shift;
      logic [RADIX_W-1:0] radix;
   } cell_ctrl_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] dx;
      dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 6'd10) begin
         digit_char = CH_ZERO + dx;
      end else begin
         digit_char = (upper ? CH_UA : CH_LA) + dx - 8'd10;
      end
   endfunction

endpackage

[hdl/irt_cell.sv]
`timescale 1ns / 1ps
// irt_cell: one digit cell of the conversion chain, doubles its digit
// and adds the carry from its neighbor modulo the radix; uses irt_pkg
module irt_cell
   import irt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic               carry_in,
   input  logic               valid_in,
   input  logic [DIGIT_W-1:0] shift_in,
   output logic               carry_out,
   output logic               valid_out,
   output logic [DIGIT_W-1:0] digit
);

   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               carry_ff, carry_n_in;
   logic               valid_ff, valid_n_in;
   logic [DIGIT_W:0]   sum;
   logic               ge;

   assign sum = {digit_ff, carry_in};
   assign ge  = (sum >= {1'b0, ctrl.radix});

   always_comb begin
      digit_in   = digit_ff;
      carry_n_in = 1'b0;
      valid_n_in = 1'b0;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = shift_in;
      end else begin
         valid_n_in = valid_in;
         if (valid_in) begin
            // 2d + c < 2r, so one subtract is enough
            digit_in   = ge ? DIGIT_W'(sum - {1'b0, ctrl.radix}) : sum[DIGIT_W-1:0];
            carry_n_in = ge;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         carry_ff <= carry_n_in;
         valid_ff <= valid_n_in;
      end
      digit_ff <= digit_in;
   end

   assign carry_out = carry_ff;
   assign valid_out = valid_ff;
   assign digit     = digit_ff;

endmodule

[hdl/irt_chain.sv]
`timescale 1ns / 1ps
// irt_chain: row of irt_cell digit cells, least significant first;
// bits enter at cell 0, digits leave from the top cell; uses irt_pkg
module irt_chain
   import irt_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic               bit_in,
   input  logic               bit_valid,
   output logic [DIGIT_W-1:0] top_digit
);

   logic               carry [VALUE_BITS+1];
   logic               vld   [VALUE_BITS+1];
   logic [DIGIT_W-1:0] dig   [VALUE_BITS+1];

   assign carry[0] = bit_in;
   assign vld[0]   = bit_valid;
   assign dig[0]   = '0;

   for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
      irt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .carry_in  (carry[i]),
         .valid_in  (vld[i]),
         .shift_in  (dig[i]),
         .carry_out (carry[i+1]),
         .valid_out (vld[i+1]),
         .digit     (dig[i+1])
      );
   end

   assign top_digit = dig[VALUE_BITS];

endmodule

[hdl/integer_to_radix_text.sv]
`timescale 1ns / 1ps
// integer_to_radix_text: top level, sequencer and output register around
// the irt_chain digit cells; uses irt_pkg, irt_chain, irt_cell
//
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_value, req_radix, req_format_flags
// rsp     | out       | rsp_valid, rsp_stall, rsp_character, rsp_last
//
// one number at a time: the idle state takes the transfer, then the conversion
// runs while the value bits travel skewed through the cell row, then any sign
// and prefix characters go out, then the digits shift out of the top cell
// (leading zeros dropped); a bad radix skips the conversion. rsp stalls hold
// the sequencer while it sends characters, except that leading zeros are
// dropped without waiting. reset is synchronous and clears the sequencer and
// rsp_valid.
module integer_to_radix_text
   import irt_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [RADIX_W-1:0]    req_radix,
   input  logic [FLAG_W-1:0]     req_format_flags,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_character,
   output logic                  rsp_last
);

   localparam int CONV_CYC = 2 * VALUE_BITS;
   localparam int CONV_W   = $clog2(CONV_CYC);
   localparam int EMIT_W   = $clog2(VALUE_BITS);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CONV  = 7'b0000010,
      ST_SIGN  = 7'b0000100,
      ST_PFX0  = 7'b0001000,
      ST_PFX1  = 7'b0010000,
      ST_DIGIT = 7'b0100000,
      ST_BAD   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [CHAR_W-1:0]     sign_ff, sign_in;
   logic [CHAR_W-1:0]     pfx_ff, pfx_in;
   logic                  upper_ff, upper_in;
   logic [CONV_W-1:0]     conv_ff, conv_in;
   logic [EMIT_W-1:0]     emit_ff, emit_in;
   logic                  skip_ff, skip_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;

   cell_ctrl_type         ctrl;
   logic                  bit_valid;
   logic [DIGIT_W-1:0]    top_digit;
   logic                  req_xfer, slot_free, last_digit, drop;
   logic                  neg;
   state_type             after_sign, after_pfx;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   // output register can take a new character this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign neg        = req_format_flags[FLAG_SIGNED] && req_value[VALUE_BITS-1];
   assign last_digit = (emit_ff == EMIT_W'(VALUE_BITS - 1));
   // leading zero, dropped without a transfer
   assign drop       = skip_ff && (top_digit == '0) && !last_digit;
   assign bit_valid  = (state_ff == ST_CONV) && (conv_ff < CONV_W'(VALUE_BITS));

   assign after_pfx  = ST_DIGIT;
   assign after_sign = (pfx_ff != CH_NONE) ? ST_PFX0 : ST_DIGIT;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      radix_in     = radix_ff;
      sign_in      = sign_ff;
      pfx_in       = pfx_ff;
      upper_in     = upper_ff;
      conv_in      = conv_ff;
      emit_in      = emit_ff;
      skip_in      = skip_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      last_in      = last_ff;
      ctrl.clear   = 1'b0;
      ctrl.shift   = 1'b0;
      ctrl.radix   = radix_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               radix_in = req_radix;
               upper_in = req_format_flags[FLAG_UPPER];
               mag_in   = neg ? VALUE_BITS'(-req_value) : req_value;
               sign_in  = CH_NONE;
               if (neg) begin
                  sign_in = CH_MINUS;
               end else if (req_format_flags[FLAG_SIGNED]) begin
                  if (req_format_flags[FLAG_SPACE]) begin
                     sign_in = CH_SPACE;
                  end else if (req_format_flags[FLAG_PLUS]) begin
                     sign_in = CH_PLUS;
                  end
               end
               pfx_in = CH_NONE;
               if (req_format_flags[FLAG_PREFIX]) begin
                  if (req_radix == RADIX_HEX) begin
                     pfx_in = CH_X;
                  end else if (req_radix == RADIX_OCT) begin
                     pfx_in = CH_O;
                  end
               end
               conv_in    = '0;
               emit_in    = '0;
               skip_in    = 1'b1;
               ctrl.clear = 1'b1;
               if (req_radix < RADIX_MIN || req_radix > RADIX_MAX) begin
                  state_in = ST_BAD;
               end else begin
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            // feed value msb first into cell 0, then let the skew drain
            mag_in  = mag_ff << 1;
            conv_in = conv_ff + 1'b1;
            if (conv_ff == CONV_W'(CONV_CYC - 1)) begin
               state_in = (sign_ff != CH_NONE) ? ST_SIGN : after_sign;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               char_in      = sign_ff;
               last_in      = 1'b0;
               state_in     = after_sign;
            end
         end
         ST_PFX0: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CH_ZERO;
               last_in      = 1'b0;
               state_in     = ST_PFX1;
            end
         end
         ST_PFX1: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               char_in      = pfx_ff;
               last_in      = 1'b0;
               state_in     = after_pfx;
            end
         end
         ST_DIGIT: begin
            if (drop) begin
               ctrl.shift = 1'b1;
               emit_in    = emit_ff + 1'b1;
            end else if (slot_free) begin
               ctrl.shift   = 1'b1;
               emit_in      = emit_ff + 1'b1;
               skip_in      = 1'b0;
               rsp_valid_in = 1'b1;
               char_in      = digit_char(top_digit, upper_ff);
               last_in      = last_digit;
               if (last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CH_ZERO;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         conv_ff      <= '0;
         emit_ff      <= '0;
         skip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         conv_ff      <= conv_in;
         emit_ff      <= emit_in;
         skip_ff      <= skip_in;
      end
      mag_ff   <= mag_in;
      radix_ff <= radix_in;
      sign_ff  <= sign_in;
      pfx_ff   <= pfx_in;
      upper_ff <= upper_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   irt_chain #(
      .VALUE_BITS (VALUE_BITS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .bit_in    (mag_ff[VALUE_BITS-1]),
      .bit_valid (bit_valid),
      .top_digit (top_digit)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule
